// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the execute core RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define BVM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define BVM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bvm_pkg.sv =====
// Shared types and constants for the byte register execute core.
// No dependencies; used by every module of the block.
package bvm_pkg;

	// Default configuration of the machine
	localparam int REG_COUNT_DEF   = 16;
	localparam int IP_WIDTH_DEF    = 16;
	localparam int INSTR_BYTES_DEF = 2;

	// Depth of the queue between front and back
	localparam int FIFO_DEPTH = 4;

	// Operation codes
	typedef enum logic [4:0] {
		OP_RET  = 5'd0,
		OP_INC  = 5'd1,
		OP_DEC  = 5'd2,
		OP_MOV  = 5'd3,
		OP_JMP  = 5'd4,
		OP_JZ   = 5'd5,
		OP_JNZ  = 5'd6,
		OP_JFE  = 5'd7,
		OP_MOVC = 5'd8,
		OP_LSR  = 5'd9,
		OP_LSL  = 5'd10,
		OP_IN   = 5'd11,
		OP_OUT  = 5'd12,
		OP_ADD  = 5'd13,
		OP_SUB  = 5'd14,
		OP_XOR  = 5'd15,
		OP_OR   = 5'd16
	} op_t;

	// Jump condition class
	typedef enum logic [2:0] {
		JC_NONE     = 3'd0,
		JC_ALWAYS   = 3'd1,
		JC_ZERO_CLR = 3'd2,
		JC_ZERO_SET = 3'd3,
		JC_END      = 3'd4
	} jcond_t;

	// Decoded item as it travels through the queue
	typedef struct packed {
		op_t        op;
		logic       fault;
		logic       writes;
		jcond_t     jcond;
		logic [3:0] ra;
		logic [3:0] rb;
		logic [3:0] wa;
		logic [7:0] operand;
		logic [7:0] in_byte;
		logic       in_end;
	} item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ===== hdl/bvm_front.sv =====
// Front end: accepts input items and classifies the operation code.
// Depends on bvm_pkg; feeds bvm_fifo.
module bvm_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         operation,
	input  logic signed [7:0]  operand,
	input  logic [7:0]         in_byte,
	input  logic               in_end,
	input  bvm_pkg::fifo_stat_t stat,
	output logic               push,
	output bvm_pkg::item_t     push_item
);

	// Stall only on a full queue
	assign in_stall = stat.full;
	assign push     = in_valid && !stat.full;

	// Classify the operation
	always_comb begin
		push_item         = '0;
		push_item.op      = bvm_pkg::OP_RET;
		push_item.fault   = 1'b0;
		push_item.writes  = 1'b0;
		push_item.jcond   = bvm_pkg::JC_NONE;
		push_item.ra      = operand[3:0];
		push_item.rb      = operand[7:4];
		push_item.wa      = operand[3:0];
		push_item.operand = operand;
		push_item.in_byte = in_byte;
		push_item.in_end  = in_end;
		unique case (operation)
			bvm_pkg::OP_RET: begin
				push_item.op = bvm_pkg::OP_RET;
			end
			bvm_pkg::OP_INC, bvm_pkg::OP_DEC, bvm_pkg::OP_MOV, bvm_pkg::OP_LSR,
			bvm_pkg::OP_LSL, bvm_pkg::OP_IN, bvm_pkg::OP_ADD, bvm_pkg::OP_SUB,
			bvm_pkg::OP_XOR, bvm_pkg::OP_OR: begin
				push_item.op     = bvm_pkg::op_t'(operation);
				push_item.writes = 1'b1;
			end
			bvm_pkg::OP_MOVC: begin
				push_item.op     = bvm_pkg::OP_MOVC;
				push_item.writes = 1'b1;
				push_item.wa     = 4'd0;
			end
			bvm_pkg::OP_JMP: begin
				push_item.op    = bvm_pkg::OP_JMP;
				push_item.jcond = bvm_pkg::JC_ALWAYS;
			end
			bvm_pkg::OP_JZ: begin
				push_item.op    = bvm_pkg::OP_JZ;
				push_item.jcond = bvm_pkg::JC_ZERO_CLR;
			end
			bvm_pkg::OP_JNZ: begin
				push_item.op    = bvm_pkg::OP_JNZ;
				push_item.jcond = bvm_pkg::JC_ZERO_SET;
			end
			bvm_pkg::OP_JFE: begin
				push_item.op    = bvm_pkg::OP_JFE;
				push_item.jcond = bvm_pkg::JC_END;
			end
			bvm_pkg::OP_OUT: begin
				push_item.op = bvm_pkg::OP_OUT;
			end
			default: begin
				push_item.fault = 1'b1;
			end
		endcase
	end

endmodule

// ===== hdl/bvm_fifo.sv =====
// Short queue of decoded items between front and back.
// Depends on bvm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bvm_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bvm_pkg::item_t      push_item,
	input  logic                pop,
	output bvm_pkg::item_t      head,
	output bvm_pkg::fifo_stat_t stat
);

	localparam int DEPTH = bvm_pkg::FIFO_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bvm_pkg::item_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`BVM_ASSERT_NXT(a_fifo_grow, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + CNT_W'(1), "queue count did not grow on push")
	`BVM_ASSERT_NXT(a_fifo_shrink, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - CNT_W'(1), "queue count did not shrink on pop")

endmodule

// ===== hdl/bvm_back.sv =====
// Back end: register file read stage, execute stage and result register.
// Depends on bvm_pkg and assert_macros.svh; pulls items from bvm_fifo.
`include "assert_macros.svh"

module bvm_back #(
	parameter int REG_COUNT   = bvm_pkg::REG_COUNT_DEF,
	parameter int IP_WIDTH    = bvm_pkg::IP_WIDTH_DEF,
	parameter int INSTR_BYTES = bvm_pkg::INSTR_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bvm_pkg::item_t      head,
	input  bvm_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [15:0]         next_ip,
	output logic                out_valid,
	output logic [7:0]          out_byte,
	output logic                halted,
	output logic                zero_state,
	output logic                end_state,
	output logic                fault
);

	localparam int RA_W = $clog2(REG_COUNT);

	// Register file with per-entry valid bits (invalid reads as zero)
	logic [7:0]           rf_q [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	// Read stage
	logic           valid_s1;
	bvm_pkg::item_t item_s1;
	logic [7:0]     rd_a_s1;
	logic [7:0]     rd_b_s1;

	// Write that landed on the edge the read stage loaded
	logic       byp_en_q;
	logic [3:0] byp_idx_q;
	logic [7:0] byp_data_q;

	// Architectural state
	logic [IP_WIDTH-1:0] ip_q;
	logic                halt_q;
	logic                zero_q;
	logic                end_q;

	// Result register
	logic        res_valid_q;
	logic [15:0] next_ip_s2;
	logic        out_valid_s2;
	logic [7:0]  out_byte_s2;
	logic        halted_s2;
	logic        zero_s2;
	logic        end_s2;
	logic        fault_s2;

	logic                exec_fire;
	logic                load;
	logic [7:0]          rd_a_raw;
	logic [7:0]          rd_b_raw;
	logic [7:0]          a_val;
	logic [7:0]          b_val;
	logic [7:0]          wr_val;
	logic                take_jump;
	logic                active;
	logic                wr_go;
	logic [IP_WIDTH-1:0] ip_n;
	logic                halt_n;
	logic                zero_n;
	logic                end_n;
	logic                out_valid_n;

	// Handshake between stages
	assign exec_fire = valid_s1 && (!res_valid_q || !res_stall);
	assign load      = !stat.empty && (!valid_s1 || exec_fire);
	assign pop       = load;

	// Register reads for the item at the queue head
	always_comb begin
		rd_a_raw = '0;
		rd_b_raw = '0;
		if ((32'(head.ra) < REG_COUNT) && rf_vld_q[head.ra[RA_W-1:0]]) begin
			rd_a_raw = rf_q[head.ra[RA_W-1:0]];
		end
		if ((32'(head.rb) < REG_COUNT) && rf_vld_q[head.rb[RA_W-1:0]]) begin
			rd_b_raw = rf_q[head.rb[RA_W-1:0]];
		end
	end

	// Read stage registers
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1    <= head;
			rd_a_s1    <= rd_a_raw;
			rd_b_s1    <= rd_b_raw;
			byp_idx_q  <= item_s1.wa;
			byp_data_q <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			byp_en_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				byp_en_q <= wr_go;
			end else if (exec_fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Operands with forwarding of the write the read missed
	assign a_val = (byp_en_q && byp_idx_q == item_s1.ra) ? byp_data_q : rd_a_s1;
	assign b_val = (byp_en_q && byp_idx_q == item_s1.rb) ? byp_data_q : rd_b_s1;

	// Value to be written
	always_comb begin
		unique case (item_s1.op)
			bvm_pkg::OP_INC:  wr_val = a_val + 8'd1;
			bvm_pkg::OP_DEC:  wr_val = a_val - 8'd1;
			bvm_pkg::OP_MOV:  wr_val = b_val;
			bvm_pkg::OP_MOVC: wr_val = item_s1.operand;
			bvm_pkg::OP_LSR:  wr_val = a_val >> 1;
			bvm_pkg::OP_LSL:  wr_val = a_val << 1;
			bvm_pkg::OP_IN:   wr_val = item_s1.in_byte;
			bvm_pkg::OP_ADD:  wr_val = a_val + b_val;
			bvm_pkg::OP_SUB:  wr_val = a_val - b_val;
			bvm_pkg::OP_XOR:  wr_val = a_val ^ b_val;
			bvm_pkg::OP_OR:   wr_val = a_val | b_val;
			default:          wr_val = '0;
		endcase
	end

	// Jump conditions, polarity as the machine defines them
	always_comb begin
		unique case (item_s1.jcond)
			bvm_pkg::JC_ALWAYS:   take_jump = 1'b1;
			bvm_pkg::JC_ZERO_CLR: take_jump = !zero_q;
			bvm_pkg::JC_ZERO_SET: take_jump = zero_q;
			bvm_pkg::JC_END:      take_jump = end_q;
			default:              take_jump = 1'b0;
		endcase
	end

	// Next state; halted machines and faulting codes leave it alone
	assign active = !halt_q && !item_s1.fault;
	assign wr_go  = exec_fire && active && item_s1.writes && (32'(item_s1.wa) < REG_COUNT);

	always_comb begin
		ip_n        = ip_q;
		halt_n      = halt_q;
		zero_n      = zero_q;
		end_n       = end_q;
		out_valid_n = 1'b0;
		if (active) begin
			if (take_jump) begin
				ip_n = ip_q + IP_WIDTH'($signed(item_s1.operand));
			end else begin
				ip_n = ip_q + IP_WIDTH'(INSTR_BYTES);
			end
			if (item_s1.op == bvm_pkg::OP_RET) begin
				halt_n = 1'b1;
			end
			if (item_s1.writes) begin
				zero_n = (wr_val == 8'd0);
			end
			if (item_s1.op == bvm_pkg::OP_IN) begin
				end_n = item_s1.in_end;
			end
			out_valid_n = (item_s1.op == bvm_pkg::OP_OUT);
		end
	end

	// Register file write
	always_ff @(posedge clk) begin
		if (wr_go) begin
			rf_q[item_s1.wa[RA_W-1:0]] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (wr_go) begin
			rf_vld_q[item_s1.wa[RA_W-1:0]] <= 1'b1;
		end
	end

	// Architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q   <= '0;
			halt_q <= 1'b0;
			zero_q <= 1'b0;
			end_q  <= 1'b0;
		end else if (exec_fire) begin
			ip_q   <= ip_n;
			halt_q <= halt_n;
			zero_q <= zero_n;
			end_q  <= end_n;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			next_ip_s2   <= 16'(ip_n);
			out_valid_s2 <= out_valid_n;
			out_byte_s2  <= out_valid_n ? a_val : 8'd0;
			halted_s2    <= halt_n;
			zero_s2      <= zero_n;
			end_s2       <= end_n;
			fault_s2     <= !halt_q && item_s1.fault;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (exec_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid  = res_valid_q;
	assign next_ip    = next_ip_s2;
	assign out_valid  = out_valid_s2;
	assign out_byte   = out_byte_s2;
	assign halted     = halted_s2;
	assign zero_state = zero_s2;
	assign end_state  = end_s2;
	assign fault      = fault_s2;

	`BVM_ASSERT_NXT(a_halt_sticky, clk, arst_n, halt_q, halt_q, "halt flag cleared")
	`BVM_ASSERT_NXT(a_fault_keeps_ip, clk, arst_n, exec_fire && item_s1.fault, ip_q == $past(ip_q), "faulting item moved the pointer")
	`BVM_ASSERT_IMP(a_no_write_halted, clk, arst_n, halt_q, !wr_go, "register write while halted")
	`BVM_ASSERT_IMP(a_out_byte_idle, clk, arst_n, res_valid_q && !out_valid_s2, out_byte_s2 == 8'd0, "out_byte nonzero without output")

endmodule

// ===== hdl/byte_register_vm_execute_core.sv =====
// Top level of the byte register machine execute core.
// Depends on bvm_pkg, bvm_front, bvm_fifo and bvm_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one instruction per item:
//   operation, operand, in_byte and in_end. Result channel (res_valid /
//   res_stall) returns one item per instruction: next_ip, out_valid,
//   out_byte, halted, zero_state, end_state and fault.
//   An accepted item enters a four-entry queue, is read from the register
//   file into the read stage registers and then executed into the result
//   register. The execute stage retires one item per cycle while res_stall
//   is low, so the sustained rate is one item per cycle; register values
//   written by one item are forwarded to the next.
//   When res_stall is high the result register holds, the execute stage
//   waits, and the queue fills; in_stall rises once all four entries are
//   taken. Reset clears the registers to zero (by per-entry valid bits),
//   the pointer and all flags, and empties the queue and pipeline.
module byte_register_vm_execute_core #(
	parameter int REG_COUNT   = bvm_pkg::REG_COUNT_DEF,
	parameter int IP_WIDTH    = bvm_pkg::IP_WIDTH_DEF,
	parameter int INSTR_BYTES = bvm_pkg::INSTR_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [4:0]        operation,
	input  logic signed [7:0] operand,
	input  logic [7:0]        in_byte,
	input  logic              in_end,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [15:0]       next_ip,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              halted,
	output logic              zero_state,
	output logic              end_state,
	output logic              fault
);

	logic                push;
	logic                pop;
	bvm_pkg::item_t      push_item;
	bvm_pkg::item_t      head;
	bvm_pkg::fifo_stat_t stat;

	// Decode and accept
	bvm_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.operand   (operand),
		.in_byte   (in_byte),
		.in_end    (in_end),
		.stat      (stat),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue
	bvm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// Execute
	bvm_back #(
		.REG_COUNT   (REG_COUNT),
		.IP_WIDTH    (IP_WIDTH),
		.INSTR_BYTES (INSTR_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.stat       (stat),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.next_ip    (next_ip),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.halted     (halted),
		.zero_state (zero_state),
		.end_state  (end_state),
		.fault      (fault)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for byte_register_vm_execute_core: directed and random instructions,
// predicted against an in-bench model of the register machine.
// Depends on bvm_pkg and the execute core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_HOLD = 240;
	localparam logic [15:0] IP_STEP = 16'(bvm_pkg::INSTR_BYTES_DEF);
	localparam logic [4:0] OP_UNUSED_LO = 5'd17;
	localparam logic [4:0] OP_UNUSED_HI = 5'd31;

	// one instruction item plus the idle cycles the sender takes after it
	typedef struct {
		logic [4:0] op;
		logic [7:0] opnd;
		logic [7:0] ib;
		logic       ie;
		int         gap;
	} instr_t;

	// one retired instruction as the result channel reports it
	typedef struct packed {
		logic [15:0] ip;
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        halted;
		logic        zero;
		logic        endf;
		logic        fault;
	} retire_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] operation = '0;
	logic signed [7:0] operand = '0;
	logic [7:0] in_byte = '0;
	logic in_end = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [15:0] next_ip;
	logic out_valid;
	logic [7:0] out_byte;
	logic halted;
	logic zero_state;
	logic end_state;
	logic fault;

	instr_t program_q[$];
	retire_t retire_q[$];
	instr_t next_instr;
	int idle_left = 0;
	int hold_left = 0;
	int results_seen = 0;
	int rx_wait;
	int errors = 0;
	int cycle_count = 0;

	// machine state as predicted
	logic [7:0] vm_regs[16];
	logic [15:0] vm_ip;
	logic vm_halt;
	logic vm_zero;
	logic vm_end;

	byte_register_vm_execute_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.operand(operand),
		.in_byte(in_byte),
		.in_end(in_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.next_ip(next_ip),
		.out_valid(out_valid),
		.out_byte(out_byte),
		.halted(halted),
		.zero_state(zero_state),
		.end_state(end_state),
		.fault(fault)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// register write: zero flag follows the written value
	function automatic void write_reg(logic [3:0] idx, logic [7:0] v);
		vm_regs[idx] = v;
		vm_zero = (v == 8'd0);
	endfunction

	// execute one instruction on the predicted machine
	task automatic execute_instr(input instr_t it, output retire_t r);
		logic [3:0] ra;
		logic [3:0] rb;
		logic [15:0] offs;
		logic seq;
		ra = it.opnd[3:0];
		rb = it.opnd[7:4];
		offs = {{8{it.opnd[7]}}, it.opnd};
		seq = 1'b1;
		r = '0;
		if (!vm_halt) begin
			case (it.op)
				bvm_pkg::OP_RET: vm_halt = 1'b1;
				bvm_pkg::OP_INC: write_reg(ra, vm_regs[ra] + 8'd1);
				bvm_pkg::OP_DEC: write_reg(ra, vm_regs[ra] - 8'd1);
				bvm_pkg::OP_MOV: write_reg(ra, vm_regs[rb]);
				bvm_pkg::OP_JMP: begin
					seq = 1'b0;
					vm_ip = vm_ip + offs;
				end
				// zero-flag jumps keep the inverted sense of the machine
				bvm_pkg::OP_JZ: if (!vm_zero) begin
					seq = 1'b0;
					vm_ip = vm_ip + offs;
				end
				bvm_pkg::OP_JNZ: if (vm_zero) begin
					seq = 1'b0;
					vm_ip = vm_ip + offs;
				end
				bvm_pkg::OP_JFE: if (vm_end) begin
					seq = 1'b0;
					vm_ip = vm_ip + offs;
				end
				bvm_pkg::OP_MOVC: write_reg(4'd0, it.opnd);
				bvm_pkg::OP_LSR: write_reg(ra, vm_regs[ra] >> 1);
				bvm_pkg::OP_LSL: write_reg(ra, vm_regs[ra] << 1);
				bvm_pkg::OP_IN: begin
					write_reg(ra, it.ib);
					vm_end = it.ie;
				end
				bvm_pkg::OP_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte = vm_regs[ra];
				end
				bvm_pkg::OP_ADD: write_reg(ra, vm_regs[ra] + vm_regs[rb]);
				bvm_pkg::OP_SUB: write_reg(ra, vm_regs[ra] - vm_regs[rb]);
				bvm_pkg::OP_XOR: write_reg(ra, vm_regs[ra] ^ vm_regs[rb]);
				bvm_pkg::OP_OR: write_reg(ra, vm_regs[ra] | vm_regs[rb]);
				default: begin
					r.fault = 1'b1;
					seq = 1'b0;
				end
			endcase
			if (seq)
				vm_ip = vm_ip + IP_STEP;
		end
		r.ip = vm_ip;
		r.halted = vm_halt;
		r.zero = vm_zero;
		r.endf = vm_end;
	endtask

	task automatic report(string msg);
		errors++;
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report($sformatf("%s got 0x%0h expected 0x%0h", what, got, want));
	endtask

	// stimulus helpers
	function automatic logic [7:0] reg_pair(int dst, int src);
		return {4'(src), 4'(dst)};
	endfunction

	function automatic int pick_reg();
		return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
	endfunction

	task automatic add_instr(logic [4:0] op, logic [7:0] opnd, logic [7:0] ib, logic ie, int gap);
		instr_t it;
		it.op = op;
		it.opnd = opnd;
		it.ib = ib;
		it.ie = ie;
		it.gap = gap;
		program_q.push_back(it);
	endtask

	task automatic add_directed(logic [4:0] op, logic [7:0] opnd, logic [7:0] ib = 8'h00,
			logic ie = 1'b0);
		add_instr(op, opnd, ib, ie, $urandom_range(0, 7));
	endtask

	task automatic build_program();
		int op_pick;
		int gap;
		logic [4:0] op;
		logic [7:0] opnd;
		logic [7:0] ib;
		// directed: wraps, flag-driven jumps both ways, every operation but RET, unknown codes
		add_directed(bvm_pkg::OP_IN, reg_pair(1, 0), 8'hFF, 1'b0);
		add_directed(bvm_pkg::OP_INC, reg_pair(1, 0));
		add_directed(bvm_pkg::OP_JZ, 8'h10);
		add_directed(bvm_pkg::OP_JNZ, 8'h80);
		add_directed(bvm_pkg::OP_DEC, reg_pair(2, 0));
		add_directed(bvm_pkg::OP_JZ, 8'h7F);
		add_directed(bvm_pkg::OP_JNZ, 8'hF0);
		add_directed(bvm_pkg::OP_MOVC, 8'h80);
		add_directed(bvm_pkg::OP_LSL, reg_pair(0, 0));
		add_directed(bvm_pkg::OP_MOVC, 8'h81);
		add_directed(bvm_pkg::OP_LSR, reg_pair(0, 0));
		add_directed(bvm_pkg::OP_MOV, reg_pair(3, 0));
		add_directed(bvm_pkg::OP_ADD, reg_pair(3, 2));
		add_directed(bvm_pkg::OP_SUB, reg_pair(3, 3));
		add_directed(bvm_pkg::OP_XOR, reg_pair(4, 2));
		add_directed(bvm_pkg::OP_OR, reg_pair(15, 4));
		add_directed(bvm_pkg::OP_OUT, reg_pair(15, 0));
		add_directed(bvm_pkg::OP_JFE, 8'h40);
		add_directed(bvm_pkg::OP_IN, reg_pair(5, 0), 8'h00, 1'b1);
		add_directed(bvm_pkg::OP_JFE, 8'h7F);
		add_directed(bvm_pkg::OP_JMP, 8'h00);
		add_directed(OP_UNUSED_HI, 8'hFF);
		add_directed(OP_UNUSED_LO, 8'h00);
		add_directed(bvm_pkg::OP_IN, reg_pair(6, 0), 8'hAA, 1'b1);
		add_directed(bvm_pkg::OP_IN, reg_pair(6, 0), 8'h55, 1'b0);
		// random: dense register reuse so values feed each other
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op_pick = $urandom_range(0, 99);
			if (op_pick < 5)
				op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
			else
				op = 5'($urandom_range(bvm_pkg::OP_INC, bvm_pkg::OP_OR));
			if (op inside {bvm_pkg::OP_JMP, bvm_pkg::OP_JZ, bvm_pkg::OP_JNZ, bvm_pkg::OP_JFE,
					bvm_pkg::OP_MOVC} || op >= OP_UNUSED_LO)
				opnd = 8'($urandom_range(0, 255));
			else
				opnd = reg_pair(pick_reg(), pick_reg());
			case ($urandom_range(0, 9))
				0: ib = 8'h00;
				1: ib = 8'hFF;
				default: ib = 8'($urandom_range(0, 255));
			endcase
			// every third block of 100 items goes without idle cycles
			gap = ((i / 100) % 3 == 1) ? 0 : $urandom_range(0, 7);
			add_instr(op, opnd, ib, ($urandom_range(0, 9) < 3), gap);
		end
		// halt, then items that must leave the state alone
		add_directed(bvm_pkg::OP_RET, 8'h00);
		add_directed(bvm_pkg::OP_OUT, reg_pair(1, 0));
		add_directed(bvm_pkg::OP_INC, reg_pair(1, 0));
		add_directed(OP_UNUSED_LO, 8'h01);
		add_directed(bvm_pkg::OP_IN, reg_pair(2, 0), 8'h3C, 1'b1);
		add_directed(bvm_pkg::OP_JMP, 8'h20);
		add_directed(bvm_pkg::OP_RET, 8'h00);
	endtask

	// driver: next item goes out once the current one is taken and its idle time is spent
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			operand <= '0;
			in_byte <= '0;
			in_end <= 1'b0;
			idle_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (idle_left != 0) begin
				in_valid <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (program_q.size() != 0) begin
				next_instr = program_q.pop_front();
				operation <= next_instr.op;
				operand <= next_instr.opnd;
				in_byte <= next_instr.ib;
				in_end <= next_instr.ie;
				in_valid <= 1'b1;
				idle_left <= next_instr.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls after results, none in every third block of 150; two long hold-offs let the queue fill up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			results_seen <= 0;
		end else if (res_valid && !res_stall) begin
			if (results_seen == 300 || results_seen == 1100)
				rx_wait = LONG_HOLD;
			else if ((results_seen / 150) % 3 == 0)
				rx_wait = 0;
			else
				rx_wait = $urandom_range(0, 7);
			results_seen <= results_seen + 1;
			res_stall <= (rx_wait != 0);
			hold_left <= rx_wait;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= (hold_left > 1);
		end
	end

	// monitor: predict accepted items, check accepted results in order
	always @(posedge clk) begin
		instr_t seen;
		retire_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen.op = operation;
				seen.opnd = operand;
				seen.ib = in_byte;
				seen.ie = in_end;
				seen.gap = 0;
				execute_instr(seen, want);
				retire_q.push_back(want);
			end
			if (res_valid && !res_stall) begin
				if (retire_q.size() == 0) begin
					report($sformatf("result with none pending, next_ip 0x%0h", next_ip));
				end else begin
					want = retire_q.pop_front();
					check_field("next_ip", next_ip, want.ip);
					check_field("out_valid", out_valid, want.out_valid);
					check_field("out_byte", out_byte, want.out_byte);
					check_field("halted", halted, want.halted);
					check_field("zero_state", zero_state, want.zero);
					check_field("end_state", end_state, want.endf);
					check_field("fault", fault, want.fault);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", retire_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		foreach (vm_regs[i])
			vm_regs[i] = 8'd0;
		vm_ip = '0;
		vm_halt = 1'b0;
		vm_zero = 1'b0;
		vm_end = 1'b0;
		build_program();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (program_q.size() != 0 || in_valid || retire_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
